[design/assert_macros.svh]
// Assertion macros used by the scheduler core.
// Assertions are checked in simulation and compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Checked at every rising clock edge, during reset too.
`define ASSERT_PROP_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_PROP_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/rmts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate-monotonic scheduler package
// Widths, register indexes, the grant record and helper functions.
// ----------------------------------------------------------------------------
package rmts_pkg;

   localparam int TASK_SLOTS     = 4;
   localparam int TASK_COUNT_DEF = 4;
   localparam int DATA_W         = 16;
   localparam int TASK_IDX_W     = 2;
   localparam int CSR_INDEX_W    = 3;
   localparam int REQ_TDATA_W    = 8;
   localparam int RSP_TDATA_W    = 24;

   // Register indexes: run lengths first, then release intervals.
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_BASE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_BASE = 3'd4;

   // Winner of one scheduling decision.
   typedef struct packed {
      logic                  busy;
      logic [TASK_IDX_W-1:0] index;
   } grant_type;

   // An interval of zero behaves as an interval of one.
   function automatic logic [DATA_W-1:0] eff_interval(input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] result;
      result = (value == '0) ? DATA_W'(1) : value;
      return result;
   endfunction

endpackage

[design/rmts_task.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate-monotonic scheduler task slot
// Holds one task's phase counter and outstanding work, reloads the work on
// each release and takes one tick off when the task is granted.
// ----------------------------------------------------------------------------
module rmts_task (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         restart,
   input  logic                         grant,
   input  logic [rmts_pkg::DATA_W-1:0]  run_ticks,
   input  logic [rmts_pkg::DATA_W-1:0]  interval_eff,
   output logic                         pending
);
   import rmts_pkg::*;

   logic [DATA_W-1:0] phase_ff, phase_in;
   logic [DATA_W-1:0] work_ff, work_in;
   logic [DATA_W-1:0] phase_cur;
   logic [DATA_W-1:0] work_now;
   logic [DATA_W:0]   phase_next;

   // A restart makes this tick time zero, which is also a release instant.
   assign phase_cur  = restart ? '0 : phase_ff;
   assign work_now   = (phase_cur == '0) ? run_ticks : work_ff;
   assign pending    = (work_now != '0);
   assign phase_next = {1'b0, phase_cur} + (DATA_W + 1)'(1);

   // The phase wraps once it reaches the interval, even after a shrink.
   always_comb begin
      phase_in = (phase_next >= {1'b0, interval_eff}) ? '0 : phase_next[DATA_W-1:0];
      work_in  = grant ? (work_now - DATA_W'(1)) : work_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         work_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         work_ff  <= work_in;
      end
   end

endmodule

[design/rmts_arbiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate-monotonic scheduler arbiter
// Picks the pending task with the smallest interval, ties to the lower index.
// ----------------------------------------------------------------------------
module rmts_arbiter #(
   parameter int TASK_COUNT = rmts_pkg::TASK_COUNT_DEF
) (
   input  logic [TASK_COUNT-1:0]        pending,
   input  logic [rmts_pkg::DATA_W-1:0]  interval_eff [TASK_COUNT],
   output rmts_pkg::grant_type          grant
);
   import rmts_pkg::*;

   logic [DATA_W-1:0] best;

   // Strict less-than keeps the earlier index on a tie.
   always_comb begin
      grant = '0;
      best  = '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (pending[i] && (!grant.busy || interval_eff[i] < best)) begin
            grant.busy  = 1'b1;
            grant.index = TASK_IDX_W'(i);
            best        = interval_eff[i];
         end
      end
   end

endmodule

[design/rate_monotonic_tick_scheduler_core.sv]
`timescale 1ns / 1ps
// A tick item is registered in the input register on acceptance; its result is
// registered in the result register; task slots and arbiter settle in between.
// Throughput: one tick per cycle while rsp_tready is high.
// Reset: synchronous; clears phases, work, tick count, run lengths (0) and
// intervals (1), and empties both pipeline registers.
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler core
// Each item is one tick; releases tasks on their intervals and reports which
// task runs on that tick, with the tick number.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rate_monotonic_tick_scheduler_core #(
   parameter int TASK_COUNT = rmts_pkg::TASK_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Tick items in.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rmts_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [0] restart, rest zero
   // Schedule results out.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rmts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [0] busy_res,
                                                            // [2:1] task_index,
                                                            // [18:3] tick_number
   // Register writes.
   input  logic                                 csr_we,
   input  logic [rmts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rmts_pkg::DATA_W-1:0]          csr_wdata
);
   import rmts_pkg::*;

   logic [DATA_W-1:0]     run_ticks_ff [TASK_SLOTS];
   logic [DATA_W-1:0]     interval_ff  [TASK_SLOTS];
   logic [DATA_W-1:0]     interval_eff [TASK_COUNT];

   logic                  in_valid_ff;
   logic                  in_restart_ff;
   logic                  advance;

   logic [DATA_W-1:0]     tick_ff, tick_in, tick_now;
   logic [TASK_COUNT-1:0] pending;
   logic [TASK_COUNT-1:0] grant_vec;
   grant_type             grant;

   logic                  rsp_valid_ff;
   grant_type             rsp_grant_ff;
   logic [DATA_W-1:0]     rsp_tick_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            run_ticks_ff[i] <= '0;
            interval_ff[i]  <= DATA_W'(1);
         end
      end else if (csr_we) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            if (csr_index == CSR_RUN_BASE + CSR_INDEX_W'(i)) begin
               run_ticks_ff[i] <= csr_wdata;
            end
            if (csr_index == CSR_INTERVAL_BASE + CSR_INDEX_W'(i)) begin
               interval_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // Input register; the tick is processed when the result register frees up.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_restart_ff <= req_tdata[0];
      end
   end

   // Tick counter.
   assign tick_now = in_restart_ff ? '0 : tick_ff;
   assign tick_in  = tick_now + DATA_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (advance) begin
         tick_ff <= tick_in;
      end
   end

   // Task slots.
   for (genvar g = 0; g < TASK_COUNT; g++) begin : g_task
      assign interval_eff[g] = eff_interval(interval_ff[g]);
      assign grant_vec[g]    = grant.busy && (grant.index == TASK_IDX_W'(g));

      rmts_task u_task (
         .clock        (clock),
         .reset        (reset),
         .step         (advance),
         .restart      (in_restart_ff),
         .grant        (grant_vec[g]),
         .run_ticks    (run_ticks_ff[g]),
         .interval_eff (interval_eff[g]),
         .pending      (pending[g])
      );
   end

   rmts_arbiter #(
      .TASK_COUNT (TASK_COUNT)
   ) u_arbiter (
      .pending      (pending),
      .interval_eff (interval_eff),
      .grant        (grant)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_grant_ff <= grant;
         rsp_tick_ff  <= tick_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - DATA_W - TASK_IDX_W - 1)'(0),
                        rsp_tick_ff, rsp_grant_ff.index, rsp_grant_ff.busy};

   // Checks.
   `ASSERT_PROP(a_idle_index_zero, clock, reset,
      rsp_valid_ff && !rsp_grant_ff.busy |-> rsp_grant_ff.index == '0)
   `ASSERT_PROP(a_grant_in_range, clock, reset,
      grant.busy |-> 32'(grant.index) < TASK_COUNT)
   `ASSERT_PROP(a_restart_tick_zero, clock, reset,
      advance && in_restart_ff |=> rsp_tick_ff == '0)
   `ASSERT_PROP_ALWAYS(a_reset_empties, clock,
      $past(reset) |-> !rsp_valid_ff && !in_valid_ff)

endmodule
